### hw/rtl/c2pm_pkg.sv
// Shared types, constants and address helpers for the convolution point MAC.
// Used by c2pm_eng, conv2d_point_mac_top and the testbench; c2pm_ram does not import it.
package c2pm_pkg;

  localparam int MAX_KERNELS     = 16;
  localparam int MAX_CHANNELS    = 16;
  localparam int MAX_INPUT_SIZE  = 32;
  localparam int MAX_KSIZE       = 3;
  localparam int MAX_STRIDE      = 4;

  localparam int K_TAPS  = MAX_KSIZE * MAX_KSIZE;
  localparam int W_DEPTH = MAX_KERNELS * MAX_CHANNELS * K_TAPS;
  localparam int I_DEPTH = MAX_CHANNELS * MAX_INPUT_SIZE * MAX_INPUT_SIZE;
  localparam int B_DEPTH = MAX_KERNELS;
  localparam int W_AW    = $clog2(W_DEPTH);
  localparam int I_AW    = $clog2(I_DEPTH);
  localparam int B_AW    = $clog2(B_DEPTH);

  localparam int DATA_W = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 48;

  localparam logic [1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_BIAS    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;
  localparam logic [1:0] CMD_COMPUTE = 2'd3;

  localparam logic [1:0] REG_KSIZE         = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_STRIDE        = 2'd2;
  localparam logic [1:0] REG_INPUT_SIZE    = 2'd3;

  typedef struct packed {
    logic [1:0] ksize;
    logic [4:0] channel_count;
    logic [2:0] stride;
    logic [5:0] input_size;
  } cfg_t;

  typedef struct packed {
    logic [3:0] kernel;
    logic [4:0] row;
    logic [4:0] col;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [3:0]       kernel;
    logic [4:0]       row;
    logic [4:0]       col;
    logic [SUM_W-1:0] sum;
    logic             err;
  } res_t;

  // weight layout: [kernel][channel][krow][kcol], pitch MAX_KSIZE
  function automatic logic [W_AW-1:0] wt_addr(logic [3:0] kernel, logic [3:0] channel,
                                              logic [1:0] krow, logic [1:0] kcol);
    logic [W_AW-1:0] base;
    base = W_AW'({kernel, channel}) * W_AW'(K_TAPS);
    return base + W_AW'(krow) * W_AW'(MAX_KSIZE) + W_AW'(kcol);
  endfunction

endpackage

### hw/rtl/c2pm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module c2pm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/c2pm_eng.sv
// Point engine: range checks, tap sequencer over the weight/sample memories,
// multiply stage and 48-bit accumulator. Depends on c2pm_pkg.
module c2pm_eng (
  input  logic                    clk,
  input  logic                    rst,
  input  c2pm_pkg::cfg_t          cfg,
  input  logic                    start,
  input  c2pm_pkg::req_t          req,
  input  logic                    take,
  output c2pm_pkg::res_t          res,
  output logic                    idle,
  output logic [c2pm_pkg::W_AW-1:0]   w_raddr,
  output logic [c2pm_pkg::I_AW-1:0]   i_raddr,
  output logic [c2pm_pkg::B_AW-1:0]   b_raddr,
  input  logic [c2pm_pkg::DATA_W-1:0] w_rdata,
  input  logic [c2pm_pkg::DATA_W-1:0] i_rdata,
  input  logic [c2pm_pkg::DATA_W-1:0] b_rdata
);
  import c2pm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  req_t   cur;
  logic [4:0] r0, c0;
  logic [3:0] ch;
  logic [1:0] kr, kc;
  logic first;
  logic rd_v, rd_first, rd_last;
  logic mul_v, mul_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic err;

  logic [7:0] r0_full, c0_full;
  logic cfg_ok, win_ok, last_tap;

  always_comb begin
    r0_full = 8'(req.row) * 8'(cfg.stride);
    c0_full = 8'(req.col) * 8'(cfg.stride);
    cfg_ok = (cfg.ksize != 2'd0) &&
             (cfg.channel_count != 5'd0) && (cfg.channel_count <= 5'(MAX_CHANNELS)) &&
             (cfg.stride != 3'd0) && (cfg.stride <= 3'(MAX_STRIDE)) &&
             (cfg.input_size != 6'd0) && (cfg.input_size <= 6'(MAX_INPUT_SIZE));
    win_ok = ({1'b0, r0_full} + 9'(cfg.ksize) <= 9'(cfg.input_size)) &&
             ({1'b0, c0_full} + 9'(cfg.ksize) <= 9'(cfg.input_size));
    last_tap = (5'(ch) == cfg.channel_count - 5'd1) &&
               (kr == cfg.ksize - 2'd1) && (kc == cfg.ksize - 2'd1);
  end

  assign w_raddr = wt_addr(cur.kernel, ch, kr, kc);
  assign i_raddr = {ch, 5'(r0 + 5'(kr)), 5'(c0 + 5'(kc))};
  assign b_raddr = cur.kernel;

  assign idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= (state == ST_RUN);
      mul_v <= rd_v;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (cfg_ok && win_ok) begin
              state <= ST_RUN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RUN: begin
          if (last_tap) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mul_v && mul_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= (state == ST_RUN) && first;
    rd_last  <= (state == ST_RUN) && last_tap;
    mul_last <= rd_last;
    prod     <= $signed(w_rdata) * $signed(i_rdata);
    if (state == ST_IDLE && start) begin
      cur   <= req;
      r0    <= r0_full[4:0];
      c0    <= c0_full[4:0];
      ch    <= '0;
      kr    <= '0;
      kc    <= '0;
      first <= 1'b1;
      err   <= !(cfg_ok && win_ok);
    end else if (state == ST_RUN) begin
      first <= 1'b0;
      if (kc == cfg.ksize - 2'd1) begin
        kc <= '0;
        if (kr == cfg.ksize - 2'd1) begin
          kr <= '0;
          ch <= ch + 4'd1;
        end else begin
          kr <= kr + 2'd1;
        end
      end else begin
        kc <= kc + 2'd1;
      end
    end
    if (state == ST_IDLE && start) begin
      acc <= '0;
    end else if (rd_v && rd_first) begin
      acc <= {{(SUM_W - DATA_W - 8){b_rdata[DATA_W-1]}}, b_rdata, 8'd0};
    end else if (mul_v) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  always_comb begin
    res.valid  = (state == ST_DONE);
    res.kernel = cur.kernel;
    res.row    = cur.row;
    res.col    = cur.col;
    res.sum    = acc;
    res.err    = err;
  end

endmodule

### hw/rtl/conv2d_point_mac_top.sv
// Multichannel 2D convolution point MAC: a compute transaction holds the input through
// the accept cycle, one weight/sample read pair per cycle from the single read port of
// each memory, two pipeline stages to the accumulator, then the load into the output
// register; a rejected compute (bad configuration or window past the edge) goes straight
// to the done state, and a weight, bias or sample write is written in its accept cycle.
// A result waiting on a full output register holds the input. Results are signed
// Q32.16, bias is applied as bias << 8. Stores start undefined until written.
module conv2d_point_mac_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // kernel_index[3:0] channel[7:4] row[12:8] col[17:13] value[33:18]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_kernel[3:0] out_row[8:4] out_col[13:9] sum[61:14]
  output logic [0:0]  m_tuser,   // range_error[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import c2pm_pkg::*;

  cfg_t cfg;
  req_t req;
  res_t res;
  logic eng_idle, accept, start, take;
  logic [1:0]  cmd;
  logic [3:0]  in_kernel, in_channel;
  logic [4:0]  in_row, in_col;
  logic [DATA_W-1:0] in_value;
  logic w_we, b_we, i_we;
  logic [W_AW-1:0] w_raddr;
  logic [I_AW-1:0] i_raddr;
  logic [B_AW-1:0] b_raddr;
  logic [DATA_W-1:0] w_rdata, i_rdata, b_rdata;

  assign cmd        = s_tuser;
  assign in_kernel  = s_tdata[3:0];
  assign in_channel = s_tdata[7:4];
  assign in_row     = s_tdata[12:8];
  assign in_col     = s_tdata[17:13];
  assign in_value   = s_tdata[33:18];

  assign s_tready = eng_idle;
  assign accept   = s_tvalid && s_tready;
  assign start    = accept && (cmd == CMD_COMPUTE);
  assign req      = '{kernel: in_kernel, row: in_row, col: in_col};

  assign w_we = accept && (cmd == CMD_WEIGHT) &&
                (in_row < 5'(MAX_KSIZE)) && (in_col < 5'(MAX_KSIZE));
  assign b_we = accept && (cmd == CMD_BIAS);
  assign i_we = accept && (cmd == CMD_SAMPLE);

  c2pm_ram #(.WIDTH(DATA_W), .DEPTH(W_DEPTH)) u_wmem (
    .clk   (clk),
    .we    (w_we),
    .waddr (wt_addr(in_kernel, in_channel, in_row[1:0], in_col[1:0])),
    .wdata (in_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  c2pm_ram #(.WIDTH(DATA_W), .DEPTH(I_DEPTH)) u_imem (
    .clk   (clk),
    .we    (i_we),
    .waddr ({in_channel, in_row, in_col}),
    .wdata (in_value),
    .raddr (i_raddr),
    .rdata (i_rdata)
  );

  c2pm_ram #(.WIDTH(DATA_W), .DEPTH(B_DEPTH)) u_bmem (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_kernel),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  c2pm_eng u_eng (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .start   (start),
    .req     (req),
    .take    (take),
    .res     (res),
    .idle    (eng_idle),
    .w_raddr (w_raddr),
    .i_raddr (i_raddr),
    .b_raddr (b_raddr),
    .w_rdata (w_rdata),
    .i_rdata (i_rdata),
    .b_rdata (b_rdata)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ksize         <= 2'd3;
      cfg.channel_count <= 5'd1;
      cfg.stride        <= 3'd1;
      cfg.input_size    <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KSIZE:         cfg.ksize         <= cfg_data[1:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[4:0];
        REG_STRIDE:        cfg.stride        <= cfg_data[2:0];
        REG_INPUT_SIZE:    cfg.input_size    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // load the output register when it is free or being drained
  assign take = res.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {2'b00, res.sum, res.col, res.row, res.kernel};
      m_tuser <= res.err;
    end
  end

endmodule

### tb/sv/conv2d_point_mac_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv2d_point_mac_top: sends weight, bias, sample and compute
// transactions, predicts each output point from its own copy of the stores and compares it
// field by field. Depends on c2pm_pkg and the RTL under hw/rtl.
module conv2d_point_mac_top_tb;
  import c2pm_pkg::*;

  typedef struct {
    logic [3:0]  kernel;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [47:0] sum;
    logic        err;
  } point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  logic [15:0] wt_mem   [MAX_KERNELS][MAX_CHANNELS][MAX_KSIZE][MAX_KSIZE];
  bit          wt_set   [MAX_KERNELS][MAX_CHANNELS][MAX_KSIZE][MAX_KSIZE];
  logic [15:0] bias_mem [MAX_KERNELS];
  bit          bias_set [MAX_KERNELS];
  logic [15:0] smp_mem  [MAX_CHANNELS][MAX_INPUT_SIZE][MAX_INPUT_SIZE];
  bit          smp_set  [MAX_CHANNELS][MAX_INPUT_SIZE][MAX_INPUT_SIZE];

  int cfg_ksize  = 3;
  int cfg_chans  = 1;
  int cfg_stride = 1;
  int cfg_isize  = 32;

  point_t expected_points[$];
  int     tx_idle_pct = 7;
  int     rx_idle_pct = 61;
  int     rx_hold = 0;
  int     items_sent = 0;
  int     points_checked = 0;
  int     cfg_writes = 0;
  int     fail_count = 0;

  conv2d_point_mac_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : point_monitor
    point_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (expected_points.size() == 0) begin
        $error("unexpected output point: kernel %0d row %0d col %0d",
               m_tdata[3:0], m_tdata[8:4], m_tdata[13:9]);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        check_field("out_kernel", 48'(want.kernel), 48'(m_tdata[3:0]));
        check_field("out_row", 48'(want.row), 48'(m_tdata[8:4]));
        check_field("out_col", 48'(want.col), 48'(m_tdata[13:9]));
        check_field("sum", want.sum, m_tdata[61:14]);
        check_field("range_error", 48'(want.err), 48'(m_tuser[0]));
        points_checked++;
      end
    end
  end

  function automatic bit window_ok(int r, int c);
    if (cfg_ksize < 1 || cfg_ksize > MAX_KSIZE) return 1'b0;
    if (cfg_chans < 1 || cfg_chans > MAX_CHANNELS) return 1'b0;
    if (cfg_stride < 1 || cfg_stride > MAX_STRIDE) return 1'b0;
    if (cfg_isize < 1 || cfg_isize > MAX_INPUT_SIZE) return 1'b0;
    return (r * cfg_stride + cfg_ksize <= cfg_isize) && (c * cfg_stride + cfg_ksize <= cfg_isize);
  endfunction

  task automatic send_item(logic [1:0] cmd, int k, int ch, int r, int c, logic [15:0] v);
    point_t p;
    longint acc;
    int     i, kr, kc;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, v, 5'(c), 5'(r), 4'(ch), 4'(k)};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    items_sent++;
    case (cmd)
      CMD_WEIGHT: begin
        if (r < MAX_KSIZE && c < MAX_KSIZE) begin
          wt_mem[k][ch][r][c] = v;
          wt_set[k][ch][r][c] = 1'b1;
        end
      end
      CMD_BIAS: begin
        bias_mem[k] = v;
        bias_set[k] = 1'b1;
      end
      CMD_SAMPLE: begin
        smp_mem[ch][r][c] = v;
        smp_set[ch][r][c] = 1'b1;
      end
      default: begin
        p.kernel = 4'(k);
        p.row    = 5'(r);
        p.col    = 5'(c);
        p.sum    = '0;
        p.err    = 1'b1;
        if (window_ok(r, c)) begin
          acc = longint'($signed(bias_mem[k])) * 256;
          for (i = 0; i < cfg_chans; i++)
            for (kr = 0; kr < cfg_ksize; kr++)
              for (kc = 0; kc < cfg_ksize; kc++)
                acc += longint'($signed(wt_mem[k][i][kr][kc])) *
                       longint'($signed(smp_mem[i][r * cfg_stride + kr][c * cfg_stride + kc]));
          p.sum = acc[47:0];
          p.err = 1'b0;
        end
        expected_points.push_back(p);
      end
    endcase
  endtask

  // If the window is valid, write every entry it reads that has no value yet; then ask for the point.
  task automatic request_point(int k, int r, int c);
    int ch, kr, kc, sr, sc;
    if (window_ok(r, c)) begin
      if (!bias_set[k])
        send_item(CMD_BIAS, k, $urandom_range(15), $urandom_range(31), $urandom_range(31),
                  16'($urandom));
      for (ch = 0; ch < cfg_chans; ch++) begin
        for (kr = 0; kr < cfg_ksize; kr++) begin
          for (kc = 0; kc < cfg_ksize; kc++) begin
            sr = r * cfg_stride + kr;
            sc = c * cfg_stride + kc;
            if (!wt_set[k][ch][kr][kc])
              send_item(CMD_WEIGHT, k, ch, kr, kc, 16'($urandom));
            if (!smp_set[ch][sr][sc])
              send_item(CMD_SAMPLE, $urandom_range(15), ch, sr, sc, 16'($urandom));
          end
        end
      end
    end
    send_item(CMD_COMPUTE, k, $urandom_range(15), r, c, 16'($urandom));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(int ks, int cc, int st, int isz);
    logic [1:0] regs [4];
    int         vals [4];
    int         widths [4];
    logic [7:0] d, mask;
    int         i;
    regs   = '{REG_KSIZE, REG_CHANNEL_COUNT, REG_STRIDE, REG_INPUT_SIZE};
    vals   = '{ks, cc, st, isz};
    widths = '{2, 5, 3, 6};
    wait_drained();
    repeat (16) @(posedge clk);
    for (i = 0; i < 4; i++) begin
      mask = 8'((1 << widths[i]) - 1);
      d = (8'($urandom) & ~mask) | (8'(vals[i]) & mask);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= d;
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      case (regs[i])
        REG_KSIZE:         cfg_ksize  = int'(d & mask);
        REG_CHANNEL_COUNT: cfg_chans  = int'(d & mask);
        REG_STRIDE:        cfg_stride = int'(d & mask);
        default:           cfg_isize  = int'(d & mask);
      endcase
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    request_point(0, 30, 30);
    request_point(0, 29, 29);
  endtask

  task automatic test_value_extremes();
    set_config(1, 1, 1, 32);
    send_item(CMD_BIAS, 15, 0, 0, 0, 16'h8000);
    send_item(CMD_WEIGHT, 15, 0, 0, 0, 16'h8000);
    send_item(CMD_SAMPLE, 0, 0, 31, 31, 16'h8000);
    request_point(15, 31, 31);
    // drop: kernel row or column past the weight store
    send_item(CMD_WEIGHT, 15, 0, 3, 3, 16'h1234);
    send_item(CMD_WEIGHT, 15, 15, 31, 31, 16'h5678);
    request_point(15, 31, 31);
    send_item(CMD_BIAS, 15, 15, 31, 31, 16'h7fff);
    send_item(CMD_WEIGHT, 15, 0, 0, 0, 16'h7fff);
    send_item(CMD_SAMPLE, 15, 0, 31, 31, 16'h7fff);
    send_item(CMD_SAMPLE, 15, 15, 31, 31, 16'hffff);
    request_point(15, 31, 31);
  endtask

  task automatic test_bad_config();
    set_config(0, 1, 1, 32);
    request_point(15, 0, 0);
    set_config(3, 0, 1, 32);
    request_point(0, 31, 31);
    set_config(3, 31, 1, 32);
    request_point(0, 0, 0);
    set_config(3, 1, 0, 32);
    request_point(7, 1, 2);
    set_config(3, 1, 7, 32);
    request_point(8, 2, 1);
    set_config(3, 1, 1, 0);
    request_point(1, 0, 0);
    set_config(3, 1, 1, 63);
    request_point(14, 0, 0);
  endtask

  task automatic test_window_edge();
    set_config(3, 2, 2, 9);
    request_point(5, 3, 3);
    request_point(5, 4, 0);
    request_point(5, 0, 4);
  endtask

  task automatic test_config_extremes();
    set_config(3, 16, 4, 32);
    request_point(7, 7, 7);
    request_point(7, 7, 8);
    set_config(1, 1, 1, 1);
    request_point(9, 0, 0);
    request_point(9, 1, 0);
  endtask

  task automatic test_output_stall();
    int n;
    tx_idle_pct = 0;
    set_config(2, 2, 1, 5);
    for (n = 0; n < 4; n++) request_point(3, n, n);
    wait_drained();
    // hold the output long enough that the block backs up into its input
    rx_hold = 400;
    for (n = 0; n < 16; n++) request_point(3, n % 4, 3 - n % 4);
    wait_drained();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_cfg, int n_items);
    int n, ks, cc, st, isz, span, lim, stop;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (n = 0; n < n_cfg; n++) begin
      ks  = $urandom_range(1, 3);
      cc  = ($urandom_range(4) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 3);
      st  = $urandom_range(1, 4);
      isz = ($urandom_range(4) == 0) ? $urandom_range(ks, 32) : $urandom_range(ks, ks + 6);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       ks  = 0;
          1:       cc  = $urandom_range(1) ? 0 : $urandom_range(17, 31);
          2:       st  = $urandom_range(1) ? 0 : $urandom_range(5, 7);
          default: isz = $urandom_range(1) ? 0 : $urandom_range(33, 63);
        endcase
      end
      set_config(ks, cc, st, isz);
      span = (cfg_stride > 0 && cfg_isize >= cfg_ksize) ?
             (cfg_isize - cfg_ksize) / cfg_stride : 0;
      if (span > 31) span = 31;
      lim = (cfg_isize > 0) ? cfg_isize - 1 : 0;
      if (lim > 31) lim = 31;
      stop = items_sent + n_items / n_cfg;
      while (items_sent < stop) begin
        case ($urandom_range(9))
          0, 1, 2, 3:
            request_point($urandom_range(15), $urandom_range(span), $urandom_range(span));
          4:
            request_point($urandom_range(15), $urandom_range(31), $urandom_range(31));
          5, 6:
            send_item(CMD_SAMPLE, $urandom_range(15), $urandom_range(15),
                      $urandom_range(1) ? $urandom_range(31) : $urandom_range(lim),
                      $urandom_range(1) ? $urandom_range(31) : $urandom_range(lim),
                      16'($urandom));
          7, 8:
            send_item(CMD_WEIGHT, $urandom_range(15), $urandom_range(15),
                      ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(2),
                      ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(2),
                      16'($urandom));
          default:
            send_item(CMD_BIAS, $urandom_range(15), $urandom_range(15), $urandom_range(31),
                      $urandom_range(31), 16'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_value_extremes();
    test_bad_config();
    test_window_edge();
    test_config_extremes();
    test_output_stall();
    test_random_traffic(7, 61, 5, 165);
    test_random_traffic(61, 7, 5, 165);
    test_random_traffic(0, 0, 5, 165);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("summary: %0d input transactions, %0d output points checked, %0d register writes",
             items_sent, points_checked, cfg_writes);
    $display("summary: value and window edges, bad settings, output stall, random traffic");
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
